>>> rtl/gtgl_pkg.sv
// shared types, constants and address/placement functions for the glyph layout block
package gtgl_pkg;

  localparam int unsigned SCREEN_WIDTH  = 128;
  localparam int unsigned SCREEN_HEIGHT = 64;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FONT_MODE    = 3'd0,
    REG_HANZI12_BASE = 3'd1,
    REG_ASCII16_BASE = 3'd2,
    REG_ASCII12_BASE = 3'd3,
    REG_READ_COMMAND = 3'd4
  } cfg_reg_e;

  localparam logic [7:0] READ_CMD_RESET = 8'h03;

  // text codes
  localparam logic [7:0] CHR_NUL   = 8'h00;
  localparam logic [7:0] CHR_LF    = 8'h0A;
  localparam logic [7:0] CHR_CR    = 8'h0D;
  localparam logic [7:0] ASCII_LO  = 8'h20;
  localparam logic [7:0] ASCII_HI  = 8'h7E;

  // gb2312 zones
  localparam logic [7:0]  HZ_FIRST      = 8'hA1;
  localparam logic [7:0]  HZ_SYM_END    = 8'hA3;
  localparam logic [7:0]  HZ_MSB_A9     = 8'hA9;
  localparam logic [7:0]  HZ_L1_FIRST   = 8'hB0;
  localparam logic [7:0]  HZ_L1_LAST    = 8'hF7;
  localparam logic [6:0]  HZ_ROW        = 7'd94;
  localparam logic [12:0] HZ_A9_OFS     = 13'd282;
  localparam logic [12:0] HZ_L1_OFS16   = 13'd846;
  localparam logic [12:0] HZ_L1_OFS12   = 13'd376;

  typedef struct packed {
    logic        glyph_kind;
    logic [7:0]  rom_command;
    logic [23:0] rom_address;
    logic [5:0]  glyph_bytes;
    logic [6:0]  pos_x;
    logic [5:0]  pos_y;
    logic        last;
  } glyph_t;

  typedef struct packed {
    logic       emit;
    logic [8:0] nx;
    logic [8:0] ny;
    logic [6:0] px;
    logic [5:0] py;
  } place_t;

  typedef struct packed {
    logic first;
    logic second;
  } push_t;

  function automatic logic [4:0] line_height(input logic fm);
    return fm ? 5'd12 : 5'd16;
  endfunction

  function automatic logic [23:0] hanzi_addr(input logic [7:0] msb, input logic [7:0] lsb,
                                             input logic fm, input logic [23:0] base12);
    logic [6:0]  lo;
    logic [6:0]  row;
    logic [12:0] idx;
    logic        ok;
    lo  = 7'(lsb - HZ_FIRST);
    row = 7'd0;
    idx = 13'd0;
    ok  = 1'b1;
    if (lsb < HZ_FIRST) begin
      ok = 1'b0;
    end else if (msb == HZ_MSB_A9) begin
      idx = HZ_A9_OFS + 13'(lo);
    end else if (msb >= HZ_FIRST && msb <= HZ_SYM_END) begin
      row = 7'(msb - HZ_FIRST);
      idx = 13'(row) * 13'(HZ_ROW) + 13'(lo);
    end else if (msb >= HZ_L1_FIRST && msb <= HZ_L1_LAST) begin
      row = 7'(msb - HZ_L1_FIRST);
      idx = (fm ? HZ_L1_OFS12 : HZ_L1_OFS16) + 13'(row) * 13'(HZ_ROW) + 13'(lo);
    end else begin
      ok = 1'b0;
    end
    if (!ok) return 24'd0;
    if (fm) return 24'(idx) * 24'd24 + base12;
    return 24'({idx, 5'b0});
  endfunction

  function automatic logic [23:0] ascii_addr(input logic [7:0] code, input logic fm,
                                             input logic [23:0] base16,
                                             input logic [23:0] base12);
    logic [6:0] ofs;
    ofs = 7'(code - ASCII_LO);
    if (code < ASCII_LO || code > ASCII_HI) return 24'd0;
    if (fm) return 24'(ofs) * 24'd12 + base12;
    return 24'({ofs, 4'b0}) + base16;
  endfunction

  // cursor advance with line wrap and bottom check
  function automatic place_t place(input logic [8:0] cx, input logic [8:0] cy,
                                   input logic kind, input logic fm);
    place_t     p;
    logic [4:0] w;
    logic [4:0] h;
    logic [8:0] x1;
    logic [8:0] y1;
    h  = line_height(fm);
    w  = kind ? (fm ? 5'd12 : 5'd16) : (fm ? 5'd6 : 5'd8);
    x1 = cx;
    y1 = cy;
    if (({1'b0, cx} + 10'(w)) > 10'(SCREEN_WIDTH)) begin
      x1 = 9'd0;
      y1 = 9'(cy + 9'(h));
    end
    p.emit = !(({1'b0, y1} + 10'(h)) > 10'(SCREEN_HEIGHT));
    p.px   = x1[6:0];
    p.py   = y1[5:0];
    p.nx   = p.emit ? 9'(x1 + 9'(w)) : x1;
    p.ny   = y1;
    return p;
  endfunction

endpackage

>>> rtl/gtgl_in_if.sv
// text byte channel
interface gtgl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       begin_req;
  logic [7:0] start_x;
  logic [7:0] start_y;

  modport source (output valid, text_byte, begin_req, start_x, start_y, input ready);
  modport sink (input valid, text_byte, begin_req, start_x, start_y, output ready);
endinterface

>>> rtl/gtgl_out_if.sv
// glyph result channel
interface gtgl_out_if;
  logic        valid;
  logic        ready;
  logic        glyph_kind;
  logic [7:0]  rom_command;
  logic [23:0] rom_address;
  logic [5:0]  glyph_bytes;
  logic [6:0]  pos_x;
  logic [5:0]  pos_y;
  logic        last;

  modport source (output valid, glyph_kind, rom_command, rom_address, glyph_bytes, pos_x,
                  pos_y, last, input ready);
  modport sink (input valid, glyph_kind, rom_command, rom_address, glyph_bytes, pos_x,
                pos_y, last, output ready);
endinterface

>>> rtl/gtgl_rqueue.sv
// small result queue taking up to two glyphs per cycle
module gtgl_rqueue import gtgl_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  push_t  push,
  input  glyph_t din0,
  input  glyph_t din1,
  output logic   room2,
  output logic   dvalid,
  input  logic   dready,
  output glyph_t dout
);

  glyph_t              mem [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic [QCNT_W-1:0]   count_next;
  logic                pop;

  assign pop    = dvalid && dready;
  assign dvalid = count != '0;
  assign dout   = mem[rd_ptr];
  assign room2  = count <= QCNT_W'(QDEPTH - 2);

  always_comb begin
    count_next = count + QCNT_W'(push.first) + QCNT_W'(push.second) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      wr_ptr <= wr_ptr + QPTR_W'(push.first) + QPTR_W'(push.second);
    end
  end

  always_ff @(posedge clk) begin
    if (push.first) mem[wr_ptr] <= din0;
    if (push.second) mem[QPTR_W'(wr_ptr + 1'b1)] <= din1;
  end

endmodule

>>> rtl/gb2312_text_glyph_layout_top.sv
// text layout top: input stage, glyph step logic, config registers and result queue
//
//   channel  dir  handshake      payload
//   in_ch    in   valid/ready    text_byte, begin_req, start_x, start_y
//   out_ch   out  valid/ready    glyph_kind, rom_command, rom_address, glyph_bytes,
//                                pos_x, pos_y, last
//   cfg      in   cfg_we         cfg_index, cfg_data
//
// one text byte per cycle while the queue has room: the input register feeds the step logic,
// which writes up to two glyphs into a four-entry result queue in the same cycle.
// a byte leaves the input register only while the queue has room for two glyphs, so a
// byte that flushes a held code plus its own glyph pushes both glyphs at once.
// synchronous reset: layout halted until begin_req, font_mode 0, read_command 3.
module gb2312_text_glyph_layout_top import gtgl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  gtgl_in_if.sink               in_ch,
  gtgl_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // configuration
  logic        font_mode;
  logic [23:0] hanzi12_base;
  logic [23:0] ascii16_base;
  logic [23:0] ascii12_base;
  logic [7:0]  read_command;

  // input register
  logic       s_valid;
  logic [7:0] s_byte;
  logic       s_begin;
  logic [7:0] s_x;
  logic [7:0] s_y;

  // layout state
  logic [8:0] cursor_x, cursor_x_next;
  logic [8:0] cursor_y, cursor_y_next;
  logic [7:0] held_byte, held_byte_next;
  logic       held_valid, held_valid_next;
  logic       halted, halted_next;

  logic       advance;
  logic       room2;
  push_t      push;
  glyph_t     din0, din1, res_a, res_b, head;

  logic [8:0] eff_x, eff_y, cx1, cy1, lf_y;
  logic [7:0] eff_hb;
  logic       eff_hv, eff_halt;
  logic       b_hi, printable, cont, em_a, em_b;
  logic [4:0] h;
  place_t     pa, pb;

  assign advance     = s_valid && room2;
  assign in_ch.ready = !s_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      font_mode    <= 1'b0;
      hanzi12_base <= '0;
      ascii16_base <= '0;
      ascii12_base <= '0;
      read_command <= READ_CMD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FONT_MODE:    font_mode    <= cfg_data[0];
        REG_HANZI12_BASE: hanzi12_base <= cfg_data[23:0];
        REG_ASCII16_BASE: ascii16_base <= cfg_data[23:0];
        REG_ASCII12_BASE: ascii12_base <= cfg_data[23:0];
        REG_READ_COMMAND: read_command <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s_byte  <= in_ch.text_byte;
      s_begin <= in_ch.begin_req;
      s_x     <= in_ch.start_x;
      s_y     <= in_ch.start_y;
    end
  end

  always_comb begin
    h        = line_height(font_mode);
    b_hi     = s_byte[7];
    eff_x    = s_begin ? {1'b0, s_x} : cursor_x;
    eff_y    = s_begin ? {1'b0, s_y} : cursor_y;
    eff_hv   = s_begin ? 1'b0 : held_valid;
    eff_hb   = s_begin ? 8'd0 : held_byte;
    eff_halt = s_begin ? 1'b0 : halted;

    // held code flush, or hanzi pair
    pa   = place(eff_x, eff_y, b_hi, font_mode);
    em_a = !eff_halt && eff_hv && pa.emit;
    cont = !eff_halt && (!eff_hv || (!b_hi && pa.emit));
    cx1  = eff_hv ? pa.nx : eff_x;
    cy1  = eff_hv ? pa.ny : eff_y;

    // the byte itself as an ascii glyph
    pb        = place(cx1, cy1, 1'b0, font_mode);
    printable = !b_hi && s_byte != CHR_CR && s_byte != CHR_LF && s_byte != CHR_NUL;
    em_b      = cont && printable && pb.emit;
    lf_y      = 9'(cy1 + 9'(h));

    cursor_x_next   = eff_x;
    cursor_y_next   = eff_y;
    held_valid_next = eff_hv;
    held_byte_next  = eff_hb;
    halted_next     = eff_halt;

    if (!eff_halt && eff_hv) begin
      held_valid_next = 1'b0;
      held_byte_next  = 8'd0;
      cursor_x_next   = pa.nx;
      cursor_y_next   = pa.ny;
      if (!pa.emit) halted_next = 1'b1;
    end

    if (cont) begin
      priority if (b_hi) begin
        held_byte_next  = s_byte;
        held_valid_next = 1'b1;
      end else if (s_byte == CHR_CR) begin
        cursor_x_next = 9'd0;
      end else if (s_byte == CHR_LF) begin
        cursor_x_next = 9'd0;
        cursor_y_next = lf_y;
        if (({1'b0, lf_y} + 10'(h)) > 10'(SCREEN_HEIGHT)) halted_next = 1'b1;
      end else if (s_byte == CHR_NUL) begin
        halted_next = 1'b1;
      end else begin
        cursor_x_next = pb.nx;
        cursor_y_next = pb.ny;
        if (!pb.emit) halted_next = 1'b1;
      end
    end
  end

  always_comb begin
    res_a.glyph_kind  = b_hi;
    res_a.rom_command = read_command;
    res_a.rom_address = b_hi ? hanzi_addr(eff_hb, s_byte, font_mode, hanzi12_base)
                             : ascii_addr(eff_hb, font_mode, ascii16_base, ascii12_base);
    res_a.glyph_bytes = b_hi ? (font_mode ? 6'd24 : 6'd32) : (font_mode ? 6'd12 : 6'd16);
    res_a.pos_x       = pa.px;
    res_a.pos_y       = pa.py;
    res_a.last        = !em_b;

    res_b.glyph_kind  = 1'b0;
    res_b.rom_command = read_command;
    res_b.rom_address = ascii_addr(s_byte, font_mode, ascii16_base, ascii12_base);
    res_b.glyph_bytes = font_mode ? 6'd12 : 6'd16;
    res_b.pos_x       = pb.px;
    res_b.pos_y       = pb.py;
    res_b.last        = 1'b1;

    push.first  = advance && (em_a || em_b);
    push.second = advance && em_a && em_b;
    din0        = em_a ? res_a : res_b;
    din1        = res_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x   <= '0;
      cursor_y   <= '0;
      held_byte  <= '0;
      held_valid <= 1'b0;
      halted     <= 1'b1;
    end else if (advance) begin
      cursor_x   <= cursor_x_next;
      cursor_y   <= cursor_y_next;
      held_byte  <= held_byte_next;
      held_valid <= held_valid_next;
      halted     <= halted_next;
    end
  end

  gtgl_rqueue u_rqueue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .din0   (din0),
    .din1   (din1),
    .room2  (room2),
    .dvalid (out_ch.valid),
    .dready (out_ch.ready),
    .dout   (head)
  );

  assign out_ch.glyph_kind  = head.glyph_kind;
  assign out_ch.rom_command = head.rom_command;
  assign out_ch.rom_address = head.rom_address;
  assign out_ch.glyph_bytes = head.glyph_bytes;
  assign out_ch.pos_x       = head.pos_x;
  assign out_ch.pos_y       = head.pos_y;
  assign out_ch.last        = head.last;

  // a halted layout without a new start produces nothing
  a_halt_silent: assert property (@(posedge clk) disable iff (rst)
    advance && halted && !s_begin |-> !push.first)
    else $error("glyph pushed while layout halted");

  // a two-glyph transaction ends on its second glyph only
  a_pair_last: assert property (@(posedge clk) disable iff (rst)
    push.second |-> !din0.last && din1.last)
    else $error("last flag misplaced on glyph pair");

  // a hanzi glyph always consumes a held lead byte
  a_hanzi_held: assert property (@(posedge clk) disable iff (rst)
    push.first && din0.glyph_kind |-> eff_hv && !held_valid_next)
    else $error("hanzi glyph without held lead byte");

  // a glyph pair is pushed only on an advance while the queue has room for two glyphs
  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    push.second |-> room2 && advance)
    else $error("glyph pair pushed without queue room");

endmodule
